// ===== hw/rtl/wsp_pkg.sv =====
`default_nettype none

package wsp_pkg;

	// Field widths
	localparam int COORD_W    = 24;
	localparam int COEF_W     = 21;
	localparam int PIXEL_W    = 16;
	localparam int OFFSET_W   = 40;
	localparam int SUM_FRAC   = 22;

	// Derived widths
	localparam int COEF_ROW_W = 3 * COEF_W;
	localparam int PROD_W     = COORD_W + COEF_W;
	localparam int SUM_W      = ((PROD_W + 2 > OFFSET_W) ? PROD_W + 2 : OFFSET_W) + 1;
	localparam int QUOT_W     = SUM_W - SUM_FRAC;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ROW    = 4'd0,
		REG_Y_ROW    = 4'd1,
		REG_X_OFFSET = 4'd2,
		REG_Y_OFFSET = 4'd3,
		REG_MIN_X    = 4'd4,
		REG_MAX_X    = 4'd5,
		REG_MIN_Y    = 4'd6,
		REG_MAX_Y    = 4'd7
	} wsp_reg_t;

	localparam logic signed [PIXEL_W-1:0] MAX_X_RST = PIXEL_W'(639);
	localparam logic signed [PIXEL_W-1:0] MAX_Y_RST = PIXEL_W'(479);

	typedef struct packed {
		logic        [COEF_ROW_W-1:0] x_row;
		logic        [COEF_ROW_W-1:0] y_row;
		logic signed [OFFSET_W-1:0]   x_offset;
		logic signed [OFFSET_W-1:0]   y_offset;
		logic signed [PIXEL_W-1:0]    min_x;
		logic signed [PIXEL_W-1:0]    max_x;
		logic signed [PIXEL_W-1:0]    min_y;
		logic signed [PIXEL_W-1:0]    max_y;
	} wsp_cfg_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] x0;
		logic signed [PROD_W-1:0] x1;
		logic signed [PROD_W-1:0] x2;
		logic signed [PROD_W-1:0] y0;
		logic signed [PROD_W-1:0] y1;
		logic signed [PROD_W-1:0] y2;
	} wsp_prod_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wsp_point_if.sv =====
`default_nettype none

interface wsp_point_if;
	logic                                valid;
	logic                                ready;
	logic signed [wsp_pkg::COORD_W-1:0]  point_x;
	logic signed [wsp_pkg::COORD_W-1:0]  point_y;
	logic signed [wsp_pkg::COORD_W-1:0]  point_z;

	modport source (output valid, output point_x, output point_y, output point_z,
		input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wsp_pixel_if.sv =====
`default_nettype none

interface wsp_pixel_if;
	logic                                valid;
	logic                                ready;
	logic signed [wsp_pkg::PIXEL_W-1:0]  screen_x;
	logic signed [wsp_pkg::PIXEL_W-1:0]  screen_y;

	modport source (output valid, output screen_x, output screen_y, input ready);
	modport sink (input valid, input screen_x, input screen_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wsp_cfg_if.sv =====
`default_nettype none

interface wsp_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [wsp_pkg::CFG_IDX_W-1:0]       index;
	logic [wsp_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wsp_cfg_regs.sv =====
`default_nettype none

module wsp_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	wsp_cfg_if.sink            cfg,
	output wsp_pkg::wsp_cfg_t  regs
);

	wsp_pkg::wsp_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.x_row    <= '0;
			regs_q.y_row    <= '0;
			regs_q.x_offset <= '0;
			regs_q.y_offset <= '0;
			regs_q.min_x    <= '0;
			regs_q.max_x    <= wsp_pkg::MAX_X_RST;
			regs_q.min_y    <= '0;
			regs_q.max_y    <= wsp_pkg::MAX_Y_RST;
		end else if (cfg.valid) begin
			unique case (wsp_pkg::wsp_reg_t'(cfg.index))
				wsp_pkg::REG_X_ROW:    regs_q.x_row    <= cfg.data[wsp_pkg::COEF_ROW_W-1:0];
				wsp_pkg::REG_Y_ROW:    regs_q.y_row    <= cfg.data[wsp_pkg::COEF_ROW_W-1:0];
				wsp_pkg::REG_X_OFFSET: regs_q.x_offset <= cfg.data[wsp_pkg::OFFSET_W-1:0];
				wsp_pkg::REG_Y_OFFSET: regs_q.y_offset <= cfg.data[wsp_pkg::OFFSET_W-1:0];
				wsp_pkg::REG_MIN_X:    regs_q.min_x    <= cfg.data[wsp_pkg::PIXEL_W-1:0];
				wsp_pkg::REG_MAX_X:    regs_q.max_x    <= cfg.data[wsp_pkg::PIXEL_W-1:0];
				wsp_pkg::REG_MIN_Y:    regs_q.min_y    <= cfg.data[wsp_pkg::PIXEL_W-1:0];
				wsp_pkg::REG_MAX_Y:    regs_q.max_y    <= cfg.data[wsp_pkg::PIXEL_W-1:0];
				// drop writes beyond the register list
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/wsp_mult_stage.sv =====
`default_nettype none

module wsp_mult_stage (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	wsp_point_if.sink                             point,
	input  wire logic [wsp_pkg::COEF_ROW_W-1:0]   x_row,
	input  wire logic [wsp_pkg::COEF_ROW_W-1:0]   y_row,
	input  wire logic                             down_ready,
	output logic                                  prod_valid,
	output wsp_pkg::wsp_prod_t                    prod
);

	localparam int CW = wsp_pkg::COEF_W;
	localparam int PRW = wsp_pkg::PROD_W;

	logic                                valid_s1;
	logic signed [wsp_pkg::COORD_W-1:0]  px_s1, py_s1, pz_s1;
	logic                                valid_s2;
	wsp_pkg::wsp_prod_t                  prod_s2;
	logic                                ready_s1, ready_s2;

	logic signed [CW-1:0] cx0, cx1, cx2, cy0, cy1, cy2;

	assign ready_s2   = !valid_s2 || down_ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign point.ready = ready_s1;

	assign cx0 = x_row[CW-1:0];
	assign cx1 = x_row[2*CW-1:CW];
	assign cx2 = x_row[3*CW-1:2*CW];
	assign cy0 = y_row[CW-1:0];
	assign cy1 = y_row[2*CW-1:CW];
	assign cy2 = y_row[3*CW-1:2*CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= point.valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	// hold the point
	always_ff @(posedge clk) begin
		if (ready_s1 && point.valid) begin
			px_s1 <= point.point_x;
			py_s1 <= point.point_y;
			pz_s1 <= point.point_z;
		end
	end

	// six independent products, full precision
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			prod_s2.x0 <= PRW'(px_s1) * PRW'(cx0);
			prod_s2.x1 <= PRW'(py_s1) * PRW'(cx1);
			prod_s2.x2 <= PRW'(pz_s1) * PRW'(cx2);
			prod_s2.y0 <= PRW'(px_s1) * PRW'(cy0);
			prod_s2.y1 <= PRW'(py_s1) * PRW'(cy1);
			prod_s2.y2 <= PRW'(pz_s1) * PRW'(cy2);
		end
	end

	assign prod_valid = valid_s2;
	assign prod       = prod_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/wsp_sum_clamp.sv =====
`default_nettype none

module wsp_sum_clamp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 prod_valid,
	input  wire wsp_pkg::wsp_prod_t   prod,
	input  wire wsp_pkg::wsp_cfg_t    regs,
	output logic                      up_ready,
	wsp_pixel_if.source               pixel
);

	localparam int SW = wsp_pkg::SUM_W;
	localparam int QW = wsp_pkg::QUOT_W;
	localparam int PW = wsp_pkg::PIXEL_W;
	localparam int FR = wsp_pkg::SUM_FRAC;

	logic                 valid_q;
	logic signed [PW-1:0] sx_q, sy_q;
	logic signed [PW-1:0] sx, sy;

	function automatic logic signed [PW-1:0] project(
		input logic signed [wsp_pkg::PROD_W-1:0]   p0,
		input logic signed [wsp_pkg::PROD_W-1:0]   p1,
		input logic signed [wsp_pkg::PROD_W-1:0]   p2,
		input logic signed [wsp_pkg::OFFSET_W-1:0] off,
		input logic signed [PW-1:0]                lo,
		input logic signed [PW-1:0]                hi
	);
		logic signed [SW-1:0] sum;
		logic signed [SW-1:0] adj;
		logic signed [QW-1:0] q;
		logic signed [QW-1:0] lo_w;
		logic signed [QW-1:0] hi_w;
		sum  = SW'(p0) + SW'(p1) + SW'(p2) + SW'(off);
		// bias negatives so the shift truncates toward zero
		adj  = sum + (sum[SW-1] ? SW'((1 << FR) - 1) : SW'(0));
		q    = adj[SW-1:FR];
		lo_w = QW'(lo);
		hi_w = QW'(hi);
		if (q < lo_w) q = lo_w;
		if (q > hi_w) q = hi_w;
		return q[PW-1:0];
	endfunction

	assign sx = project(prod.x0, prod.x1, prod.x2, regs.x_offset, regs.min_x, regs.max_x);
	assign sy = project(prod.y0, prod.y1, prod.y2, regs.y_offset, regs.min_y, regs.max_y);

	assign up_ready = !valid_q || pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= prod_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && prod_valid) begin
			sx_q <= sx;
			sy_q <= sy;
		end
	end

	assign pixel.valid    = valid_q;
	assign pixel.screen_x = sx_q;
	assign pixel.screen_y = sy_q;

endmodule

`default_nettype wire

// ===== hw/rtl/world_to_screen_projection.sv =====
// World-to-screen projection: each accepted world point (Q15.8 x, y, z) yields
// one clamped screen pixel. Screen x and screen y are each a three-term dot
// product of the point with a row of signed Q6.14 weights plus a Q17.22
// offset, summed exactly, truncated toward zero to an integer and clamped to
// [min, max] of that axis (a minimum above the maximum yields the maximum).
// Software folds centring, scaling, rotation, flip and slope into the weights
// and offsets. Throughput is one item per clock while the pixel output is not
// stalled. A point passes through three register stages in order: input point
// (loaded at acceptance), products (one 24x21 multiplier per weight), and the
// sum-truncate-clamp result register, which drives the pixel output. Each
// stage advances on its own, so new points are taken while a finished pixel
// waits to be read. Registers are written through the cfg channel (always
// ready) and may only change while no item is in flight; indexes beyond
// seven are dropped.

`default_nettype none

module world_to_screen_projection (
	input  wire logic     clk,
	input  wire logic     arst_n,
	wsp_point_if.sink     point,
	wsp_pixel_if.source   pixel,
	wsp_cfg_if.sink       cfg
);

	wsp_pkg::wsp_cfg_t  regs;
	wsp_pkg::wsp_prod_t prod;
	logic               prod_valid;
	logic               prod_ready;

	// configuration register file
	wsp_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// input register and product stage
	wsp_mult_stage u_mult_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.point      (point),
		.x_row      (regs.x_row),
		.y_row      (regs.y_row),
		.down_ready (prod_ready),
		.prod_valid (prod_valid),
		.prod       (prod)
	);

	// sum, truncate toward zero, clamp, hold in the output register
	wsp_sum_clamp u_sum_clamp (
		.clk        (clk),
		.arst_n     (arst_n),
		.prod_valid (prod_valid),
		.prod       (prod),
		.regs       (regs),
		.up_ready   (prod_ready),
		.pixel      (pixel)
	);

endmodule

`default_nettype wire
